/* rtl/dmeb_pkg.sv */
// ----------------------------------------------------------------------------
// dmeb_pkg
// shared types and constants of the dual motor encoder balancer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmeb_pkg;

   // event kinds
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_LEFT   = 2'd1;
   localparam logic [1:0] CMD_RIGHT  = 2'd2;
   localparam logic [1:0] CMD_MOTION = 2'd3;

   // motion codes
   localparam logic [2:0] MOT_STOP     = 3'd0;
   localparam logic [2:0] MOT_FORWARD  = 3'd1;
   localparam logic [2:0] MOT_BACKWARD = 3'd2;
   localparam logic [2:0] MOT_ROT_R    = 3'd3;
   localparam logic [2:0] MOT_ROT_L    = 3'd4;

   // bridge pin patterns
   localparam logic [3:0] PINS_FORWARD  = 4'h5;
   localparam logic [3:0] PINS_BACKWARD = 4'hA;
   localparam logic [3:0] PINS_ROT_R    = 4'h6;
   localparam logic [3:0] PINS_ROT_L    = 4'h9;
   localparam logic [3:0] PINS_OFF      = 4'h0;

   localparam logic [31:0] BASE_RESET = 32'd26843546;   // 0.1 in q4.28
   localparam logic [27:0] INC_K      = 28'd175921860;  // 1e-5 * 2^44
   localparam logic [15:0] CNT_MAX    = 16'hFFFF;
   localparam logic [9:0]  SPEED_RESET = 10'd128;

   localparam int DIST_W    = 42;
   localparam int NUM_W     = 45;
   localparam int DIV_STEPS = NUM_W;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  motion;
      logic [31:0] amount;
   } req_type;

   typedef struct packed {
      logic [3:0]  direction_pins;
      logic [15:0] duty_left;
      logic [15:0] duty_right;
      logic        running;
      logic        cmd_ok;
      logic [15:0] count_left;
      logic [15:0] count_right;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic mul;
      logic div_step;
      logic apply;
      logic duty_k;
      logic duty_l;
      logic duty_r;
      logic duty_s;
      logic out_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic tick_moving;
   } dp_status_type;

   function automatic logic [3:0] pins_of(input logic [2:0] motion);
      logic [3:0] p;
      p = PINS_OFF;
      unique case (motion)
         MOT_FORWARD:  p = PINS_FORWARD;
         MOT_BACKWARD: p = PINS_BACKWARD;
         MOT_ROT_R:    p = PINS_ROT_R;
         MOT_ROT_L:    p = PINS_ROT_L;
         default:      p = PINS_OFF;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

/* rtl/dmeb_ctrl.sv */
// ----------------------------------------------------------------------------
// dmeb_ctrl
// sequencer for event handling, serial divide and duty products
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmeb_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire dmeb_pkg::dp_status_type status,
   output dmeb_pkg::dp_cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_MUL, S_DIV, S_APPLY,
      S_DUTY_K, S_DUTY_L, S_DUTY_R, S_DUTY_S, S_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free  = !valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == S_IDLE) && req_valid;
      cmd.exec     = (state_ff == S_EXEC);
      cmd.mul      = (state_ff == S_MUL);
      cmd.div_step = (state_ff == S_DIV);
      cmd.apply    = (state_ff == S_APPLY);
      cmd.duty_k   = (state_ff == S_DUTY_K);
      cmd.duty_l   = (state_ff == S_DUTY_L);
      cmd.duty_r   = (state_ff == S_DUTY_R);
      cmd.duty_s   = (state_ff == S_DUTY_S);
      cmd.out_load = (state_ff == S_FINISH) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_EXEC;
         S_EXEC:   state_in = status.tick_moving ? S_MUL : S_DUTY_K;
         S_MUL: begin
            state_in = S_DIV;
            cnt_in   = '0;
         end
         S_DIV: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(dmeb_pkg::DIV_STEPS - 1)) state_in = S_APPLY;
         end
         S_APPLY:  state_in = S_DUTY_K;
         S_DUTY_K: state_in = S_DUTY_L;
         S_DUTY_L: state_in = S_DUTY_R;
         S_DUTY_R: state_in = S_DUTY_S;
         S_DUTY_S: state_in = S_FINISH;
         S_FINISH: if (out_free) begin
            state_in = S_IDLE;
            valid_in = 1'b1;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/dmeb_datapath.sv */
// ----------------------------------------------------------------------------
// dmeb_datapath
// counters, budget, base duties, serial divider and duty multiplier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmeb_datapath #(
   parameter int PWM_PERIOD = 4096
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire dmeb_pkg::req_type       req_payload,
   input  wire logic                    csr_valid,
   input  wire logic [9:0]              csr_data,
   input  wire dmeb_pkg::dp_cmd_type    cmd,
   output dmeb_pkg::dp_status_type      status,
   output dmeb_pkg::rsp_type            rsp_payload
);

   localparam int NW = dmeb_pkg::NUM_W;
   localparam int DW = dmeb_pkg::DIST_W;

   dmeb_pkg::req_type item_ff;
   dmeb_pkg::rsp_type rsp_ff;
   logic [9:0]        speed_ff;
   logic [15:0]       lcnt_ff, rcnt_ff;
   logic signed [DW-1:0] dist_ff;
   logic [31:0]       base_l_ff, base_r_ff;
   logic              moving_ff, ok_ff;
   logic [3:0]        pins_ff;
   logic [NW-1:0]     num_ff;
   logic [15:0]       rem_ff, div_ff;
   logic              nudge_left_ff;
   logic [25:0]       k_ff;
   logic [57:0]       prod_ff;
   logic [15:0]       duty_l_ff;
   logic [15:0]       duty_r_ff;

   // divider step
   logic [16:0] trial;
   logic        qbit;
   logic [15:0] rem_in;
   // tick apply
   logic [28:0] inc;
   logic [32:0] nsum;
   logic [31:0] nbase;
   logic [16:0] cnt_sum;
   logic signed [DW-1:0] dist_in;
   logic        stop;
   logic [15:0] fast, slow;
   logic [16:0] fs_sum;
   logic [15:0] duty_sat;
   logic        motion_ok;
   logic [DW-1:0] amt_w;

   assign status.tick_moving = (item_ff.cmd == dmeb_pkg::CMD_TICK) && moving_ff;

   assign trial  = {rem_ff, num_ff[NW-1]};
   assign qbit   = (trial >= {1'b0, div_ff});
   assign rem_in = qbit ? 16'(trial - {1'b0, div_ff}) : trial[15:0];

   assign inc     = num_ff[NW-1:16];
   assign nsum    = {1'b0, (nudge_left_ff ? base_l_ff : base_r_ff)} + {4'd0, inc};
   assign nbase   = nsum[32] ? 32'hFFFF_FFFF : nsum[31:0];
   assign cnt_sum = {1'b0, lcnt_ff} + {1'b0, rcnt_ff};
   assign dist_in = dist_ff - $signed({{(DW-16){1'b0}}, cnt_sum[16:1]});
   assign stop    = dist_in[DW-1] || (dist_in == '0);

   assign fast   = (rcnt_ff > lcnt_ff) ? rcnt_ff : lcnt_ff;
   assign slow   = (rcnt_ff > lcnt_ff) ? lcnt_ff : rcnt_ff;
   assign fs_sum = {1'b0, fast} + {1'b0, slow};

   assign duty_sat  = (prod_ff[57:35] > 23'(dmeb_pkg::CNT_MAX)) ? dmeb_pkg::CNT_MAX
                                                                : prod_ff[50:35];
   assign motion_ok = (item_ff.motion >= dmeb_pkg::MOT_FORWARD)
                   && (item_ff.motion <= dmeb_pkg::MOT_ROT_L);
   assign amt_w     = {{(DW-32){1'b0}}, item_ff.amount};

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff  <= dmeb_pkg::SPEED_RESET;
         lcnt_ff   <= 16'd1;
         rcnt_ff   <= 16'd1;
         dist_ff   <= '0;
         base_l_ff <= dmeb_pkg::BASE_RESET;
         base_r_ff <= dmeb_pkg::BASE_RESET;
         moving_ff <= 1'b0;
         pins_ff   <= dmeb_pkg::PINS_OFF;
         ok_ff     <= 1'b1;
      end else begin
         if (csr_valid) speed_ff <= csr_data;
         if (cmd.exec) begin
            ok_ff <= 1'b1;
            unique case (item_ff.cmd)
               dmeb_pkg::CMD_TICK: if (!moving_ff) begin
                  lcnt_ff <= 16'd1;
                  rcnt_ff <= 16'd1;
               end
               dmeb_pkg::CMD_LEFT:
                  if (lcnt_ff != dmeb_pkg::CNT_MAX) lcnt_ff <= lcnt_ff + 16'd1;
               dmeb_pkg::CMD_RIGHT:
                  if (rcnt_ff != dmeb_pkg::CNT_MAX) rcnt_ff <= rcnt_ff + 16'd1;
               default: begin
                  lcnt_ff <= 16'd1;
                  rcnt_ff <= 16'd1;
                  if (motion_ok) begin
                     // straight moves x256, turns x30
                     dist_ff <= (item_ff.motion <= dmeb_pkg::MOT_BACKWARD)
                              ? $signed(amt_w << 8)
                              : $signed((amt_w << 5) - (amt_w << 1));
                     pins_ff   <= dmeb_pkg::pins_of(item_ff.motion);
                     moving_ff <= 1'b1;
                  end else begin
                     dist_ff   <= '0;
                     moving_ff <= 1'b0;
                     pins_ff   <= dmeb_pkg::PINS_OFF;
                     base_l_ff <= dmeb_pkg::BASE_RESET;
                     base_r_ff <= dmeb_pkg::BASE_RESET;
                     ok_ff     <= (item_ff.motion == dmeb_pkg::MOT_STOP);
                  end
               end
            endcase
         end
         if (cmd.apply) begin
            lcnt_ff <= 16'd1;
            rcnt_ff <= 16'd1;
            if (stop) begin
               dist_ff   <= '0;
               moving_ff <= 1'b0;
               pins_ff   <= dmeb_pkg::PINS_OFF;
               base_l_ff <= dmeb_pkg::BASE_RESET;
               base_r_ff <= dmeb_pkg::BASE_RESET;
            end else begin
               dist_ff   <= dist_in;
               base_l_ff <= nudge_left_ff ? nbase : dmeb_pkg::BASE_RESET;
               base_r_ff <= nudge_left_ff ? dmeb_pkg::BASE_RESET : nbase;
            end
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_payload;
      if (cmd.mul) begin
         num_ff        <= NW'(fs_sum * dmeb_pkg::INC_K);
         div_ff        <= (slow == '0) ? 16'd1 : slow;
         rem_ff        <= '0;
         nudge_left_ff <= (rcnt_ff > lcnt_ff);
      end
      if (cmd.div_step) begin
         num_ff <= {num_ff[NW-2:0], qbit};
         rem_ff <= rem_in;
      end
      if (cmd.duty_k) k_ff <= 26'(16'(PWM_PERIOD) * speed_ff);
      if (cmd.duty_l) prod_ff <= 58'(k_ff * base_l_ff);
      if (cmd.duty_r) begin
         duty_l_ff <= duty_sat;
         prod_ff   <= 58'(k_ff * base_r_ff);
      end
      if (cmd.duty_s) duty_r_ff <= duty_sat;
      if (cmd.out_load) begin
         rsp_ff.direction_pins <= pins_ff;
         rsp_ff.duty_left      <= moving_ff ? duty_l_ff : 16'(PWM_PERIOD);
         rsp_ff.duty_right     <= moving_ff ? duty_r_ff : 16'(PWM_PERIOD);
         rsp_ff.running        <= moving_ff;
         rsp_ff.cmd_ok         <= ok_ff;
         rsp_ff.count_left     <= lcnt_ff;
         rsp_ff.count_right    <= rcnt_ff;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

/* rtl/dual_motor_encoder_balancer_top.sv */
// ----------------------------------------------------------------------------
// dual_motor_encoder_balancer_top
// two-wheel drive controller with encoder balancing
// ----------------------------------------------------------------------------
// sequence: accept, event update, then for a tick while moving a product, a
// bit-serial divide and the base and budget update, then the duty products
// throughput: one item at a time, the next is taken once the result is registered,
// and a result waits in FINISH while the previous one is stalled at the output
// reset: synchronous; counters to 1, budget to 0, bases to 0.1, stopped,
// speed multiplier to 128
`timescale 1ns / 1ps
`default_nettype none

module dual_motor_encoder_balancer_top #(
   parameter int PWM_PERIOD = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // item input
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire dmeb_pkg::req_type req_payload,
   // result output
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output dmeb_pkg::rsp_type      rsp_payload,
   // speed multiplier register
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [9:0]        csr_data
);

   dmeb_pkg::dp_cmd_type    cmd;
   dmeb_pkg::dp_status_type status;

   // the user must send register writes only while idle; the block does not enforce it and is always ready
   assign csr_ready = 1'b1;

   // sequencer: accept, event update, optional divide, duty products, result
   dmeb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // all arithmetic and state of the drive
   dmeb_datapath #(
      .PWM_PERIOD (PWM_PERIOD)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* test/dual_motor_encoder_balancer_top_tb.sv */
// ----------------------------------------------------------------------------
// dual_motor_encoder_balancer_top_tb
// checks the balancer against its own predictor of counters, budget and duties
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_motor_encoder_balancer_top_tb;

   localparam int          PERIOD_CNT = 4096;
   localparam int          WATCH_MAX  = 20000;
   localparam logic [63:0] INC_SCALE  = 64'd175921860;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   dmeb_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   dmeb_pkg::rsp_type rsp_payload;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [9:0]        csr_data = '0;

   // predictor state
   logic [9:0]         mult_q;
   logic [15:0]        cnt_l, cnt_r;
   logic signed [47:0] budget;
   logic [31:0]        base_l, base_r;
   logic               moving_q;
   logic [3:0]         pins_q;

   dmeb_pkg::rsp_type pending_rsp[$];
   int      fail_count = 0;
   int      items_sent = 0;
   int      rsp_seen   = 0;
   int      idle_cycles = 0;
   bit      hold_off = 1'b0;
   bit      no_gaps = 1'b0;

   dual_motor_encoder_balancer_top #(.PWM_PERIOD(PERIOD_CNT)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #10 clock = ~clock;

   // slower-wheel nudge: base plus ((f+s)*k/s)>>16, saturating
   function automatic logic [31:0] nudge_base(logic [31:0] b, logic [15:0] f,
                                              logic [15:0] s);
      logic [63:0] d, inc, sum;
      d   = (s == 0) ? 64'd1 : {48'd0, s};
      inc = ((({48'd0, f} + {48'd0, s}) * INC_SCALE) / d) >> 16;
      sum = {32'd0, b} + inc;
      return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   function automatic logic [15:0] duty_from(logic [31:0] b);
      logic [63:0] v;
      if (!moving_q) return PERIOD_CNT[15:0];
      v = (64'(PERIOD_CNT) * {32'd0, b} * {54'd0, mult_q}) >> 35;
      return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
   endfunction

   task automatic stop_motion();
      budget   = 0;
      moving_q = 1'b0;
      pins_q   = dmeb_pkg::PINS_OFF;
      base_l   = dmeb_pkg::BASE_RESET;
      base_r   = dmeb_pkg::BASE_RESET;
      cnt_l    = 16'd1;
      cnt_r    = 16'd1;
   endtask

   // advances the predictor by one item and queues the expected result
   task automatic predict_event(dmeb_pkg::req_type it);
      dmeb_pkg::rsp_type exp_r;
      logic    ok;
      ok = 1'b1;
      case (it.cmd)
         dmeb_pkg::CMD_TICK: begin
            if (moving_q) begin
               if (cnt_r > cnt_l) begin
                  base_l = nudge_base(base_l, cnt_r, cnt_l);
                  base_r = dmeb_pkg::BASE_RESET;
               end else begin
                  base_r = nudge_base(base_r, cnt_l, cnt_r);
                  base_l = dmeb_pkg::BASE_RESET;
               end
               budget = budget - 48'((17'(cnt_l) + 17'(cnt_r)) >> 1);
               if (budget <= 0) stop_motion();
            end
            cnt_l = 16'd1;
            cnt_r = 16'd1;
         end
         dmeb_pkg::CMD_LEFT:  if (cnt_l < dmeb_pkg::CNT_MAX) cnt_l++;
         dmeb_pkg::CMD_RIGHT: if (cnt_r < dmeb_pkg::CNT_MAX) cnt_r++;
         default: begin
            if (it.motion >= dmeb_pkg::MOT_FORWARD && it.motion <= dmeb_pkg::MOT_ROT_L) begin
               budget = (it.motion <= dmeb_pkg::MOT_BACKWARD) ? 48'(it.amount) * 256
                                                              : 48'(it.amount) * 30;
               pins_q   = dmeb_pkg::pins_of(it.motion);
               cnt_l    = 16'd1;
               cnt_r    = 16'd1;
               moving_q = 1'b1;
            end else begin
               stop_motion();
               ok = (it.motion == dmeb_pkg::MOT_STOP);
            end
         end
      endcase
      exp_r.direction_pins = pins_q;
      exp_r.duty_left      = duty_from(base_l);
      exp_r.duty_right     = duty_from(base_r);
      exp_r.running        = moving_q;
      exp_r.cmd_ok         = ok;
      exp_r.count_left     = cnt_l;
      exp_r.count_right    = cnt_r;
      pending_rsp.push_back(exp_r);
   endtask

   // sends one item, with a random gap before it unless bursting
   task automatic send_item(logic [1:0] c, logic [2:0] m, logic [31:0] a);
      dmeb_pkg::req_type it;
      int      gap;
      it.cmd = c; it.motion = m; it.amount = a;
      gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_event(it);
      items_sent++;
   endtask

   // drops valid, waits for every expected item, then lets a slow tick finish
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_speed(logic [9:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      mult_q = v;
   endtask

   // -------------------------------------------------------------------------
   // test tasks
   // -------------------------------------------------------------------------

   // every motion code, field extremes, ties and zero amount
   task automatic test_directed();
      send_item(dmeb_pkg::CMD_TICK, 3'd7, 32'hFFFF_FFFF);          // tick while stopped
      send_item(dmeb_pkg::CMD_LEFT, 3'd0, 32'd0);
      send_item(dmeb_pkg::CMD_MOTION, dmeb_pkg::MOT_FORWARD, 32'd0);   // zero amount
      send_item(dmeb_pkg::CMD_TICK, 3'd0, 32'd0);                  // stops at once
      send_item(dmeb_pkg::CMD_MOTION, dmeb_pkg::MOT_BACKWARD, 32'hFFFF_FFFF);
      send_item(dmeb_pkg::CMD_TICK, 3'd0, 32'd0);                  // tie: right grows
      send_item(dmeb_pkg::CMD_RIGHT, 3'd0, 32'd0);
      send_item(dmeb_pkg::CMD_RIGHT, 3'd0, 32'd0);
      send_item(dmeb_pkg::CMD_TICK, 3'd0, 32'd0);
      send_item(dmeb_pkg::CMD_LEFT, 3'd0, 32'd0);
      send_item(dmeb_pkg::CMD_TICK, 3'd0, 32'd0);
      send_item(dmeb_pkg::CMD_MOTION, dmeb_pkg::MOT_ROT_R, 32'd5);   // motion while moving
      send_item(dmeb_pkg::CMD_TICK, 3'd0, 32'd0);
      send_item(dmeb_pkg::CMD_MOTION, dmeb_pkg::MOT_ROT_L, 32'd3);
      send_item(dmeb_pkg::CMD_MOTION, 3'd5, 32'd9);                // invalid brakes
      send_item(dmeb_pkg::CMD_MOTION, 3'd6, 32'd9);
      send_item(dmeb_pkg::CMD_MOTION, 3'd7, 32'h8000_0000);
      send_item(dmeb_pkg::CMD_MOTION, dmeb_pkg::MOT_STOP, 32'd1);
      send_item(dmeb_pkg::CMD_MOTION, dmeb_pkg::MOT_FORWARD, 32'd1000);
   endtask

   // one wheel runs far ahead of the other, then a lopsided tick
   task automatic test_lopsided();
      no_gaps = 1'b1;
      repeat (200) send_item(dmeb_pkg::CMD_LEFT, 3'($urandom), $urandom);
      send_item(dmeb_pkg::CMD_TICK, 3'd0, 32'd0);
      no_gaps = 1'b0;
   endtask

   // mostly well-formed drives: a command, then 1-8 ticks each after pulses with random skew
   task automatic test_random(int n_items);
      int done, n, k, skew;
      done = 0;
      while (done < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(2'($urandom), 3'($urandom), $urandom);   // noise
            done++;
            continue;
         end
         send_item(dmeb_pkg::CMD_MOTION, 3'($urandom_range(1, 4)),
                   ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 40));
         done++;
         n = $urandom_range(1, 8);
         for (k = 0; k < n; k++) begin
            skew = $urandom_range(0, 2);
            repeat ($urandom_range(0, 6)) begin
               send_item((skew == 0 || $urandom_range(0, 1)) ? dmeb_pkg::CMD_LEFT
                                                             : dmeb_pkg::CMD_RIGHT,
                         3'($urandom), $urandom);
               done++;
            end
            send_item(dmeb_pkg::CMD_TICK, 3'($urandom), $urandom);
            done++;
         end
      end
   endtask

   // receiver holds off while items keep coming in
   task automatic test_backpressure();
      hold_off = 1'b1;
      no_gaps  = 1'b1;
      repeat (30) send_item(2'($urandom), 3'($urandom_range(0, 4)), $urandom_range(0, 9));
      no_gaps = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // receiver stall pattern, with a long hold-off when asked
   // -------------------------------------------------------------------------
   initial begin
      int phase, hold;
      phase = 0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            for (hold = 0; hold < 400; hold++) @(posedge clock);
            hold_off = 1'b0;
         end
         phase = (phase + 1) % 64;
         // quiet stretch in the first quarter of the pattern, random stalls later
         rsp_stall <= (phase >= 16) && ($urandom_range(0, 2) == 0);
      end
   end

   // result checker
   always @(posedge clock) begin
      dmeb_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected item %h", rsp_payload);
            fail_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_payload.direction_pins !== e.direction_pins) begin
               $error("direction_pins exp %h got %h", e.direction_pins,
                      rsp_payload.direction_pins);
               fail_count++;
            end
            if (rsp_payload.duty_left !== e.duty_left) begin
               $error("duty_left exp %0d got %0d", e.duty_left, rsp_payload.duty_left);
               fail_count++;
            end
            if (rsp_payload.duty_right !== e.duty_right) begin
               $error("duty_right exp %0d got %0d", e.duty_right, rsp_payload.duty_right);
               fail_count++;
            end
            if (rsp_payload.running !== e.running) begin
               $error("running exp %b got %b", e.running, rsp_payload.running);
               fail_count++;
            end
            if (rsp_payload.cmd_ok !== e.cmd_ok) begin
               $error("cmd_ok exp %b got %b", e.cmd_ok, rsp_payload.cmd_ok);
               fail_count++;
            end
            if (rsp_payload.count_left !== e.count_left) begin
               $error("count_left exp %0d got %0d", e.count_left, rsp_payload.count_left);
               fail_count++;
            end
            if (rsp_payload.count_right !== e.count_right) begin
               $error("count_right exp %0d got %0d", e.count_right,
                      rsp_payload.count_right);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no item moving either way
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_MAX) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // test sequence
   // -------------------------------------------------------------------------
   initial begin
      mult_q   = dmeb_pkg::SPEED_RESET;
      moving_q = 1'b0;
      stop_motion();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_lopsided();
      write_speed(10'd1023);              // top speed multiplier
      test_random(450);
      write_speed(10'd0);                 // zero multiplier
      test_random(250);
      write_speed(10'($urandom_range(1, 1022)));
      test_backpressure();
      test_random(550);
      write_speed(dmeb_pkg::SPEED_RESET);
      test_random(450);
      drain();

      $display("covered %0d items and %0d results over four speed settings,",
               items_sent, rsp_seen);
      $display("lopsided wheels, braking, invalid codes and a long receiver hold-off");
      if (fail_count == 0 && pending_rsp.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
